[rtl/wake_slot_latency_core_macros.svh]
// Assertion macros used by the checker file of the wake slot latency block.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef WAKE_SLOT_LATENCY_CORE_MACROS_SVH
`define WAKE_SLOT_LATENCY_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/wsl_pkg.sv]
// Package for the wake slot latency block: field widths, codes and the
// sequencer state type. No dependencies.
package wsl_pkg;

  // Default parameter values.
  localparam int MAX_ACTIVE_DEF = 64;
  localparam int SLOT_BITS_DEF  = 16;

  // Fixed field widths.
  localparam int ACTION_W  = 1;
  localparam int IDX_IN_W  = 6;
  localparam int SLOT_W    = 16;
  localparam int ATT_W     = 32;
  localparam int LAT_W     = 48;
  localparam int PERIOD_W  = 16;
  localparam int ACTIVE_W  = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  // Derived widths of the datapath.
  localparam int DIV_CNT_W = $clog2(ATT_W);
  localparam int PROD_W    = ATT_W + PERIOD_W;
  localparam int ACC_W     = LAT_W + 4;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_LOAD  = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SRCH,
    ST_MUL,
    ST_ADDQ,
    ST_WALK,
    ST_DONE
  } wsl_state_t;

endpackage

[rtl/wake_slot_latency_core.sv]
// Wake slot latency core: slot table, one-bit-per-cycle divider and the
// sequencer that searches and walks the table. Depends on wsl_pkg.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    action, slot index/value, query fields
//   out_     output     out_valid / out_ready  latency
//   cfg_     input      cfg_we                 cfg_index, cfg_wdata
//
// A load transaction is taken without leaving the idle state and gives no result. A query
// runs the divider, searches the table entry by entry, forms and adds the whole-period
// product, walks one slot per unit of the division remainder and delivers its result; only
// then is the next transaction taken. The divider and the table's registered read port set
// the pace of a query. Reset is synchronous and active low; the slot table is not cleared. A
// waiting result lets the next query run, but that query holds, with in_ready low, at its last cycle.
module wake_slot_latency_core #(
  parameter int MAX_ACTIVE = wsl_pkg::MAX_ACTIVE_DEF,
  parameter int SLOT_BITS  = wsl_pkg::SLOT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [wsl_pkg::ACTION_W-1:0]   in_action,
  input  logic [wsl_pkg::IDX_IN_W-1:0]   in_slot_index,
  input  logic [wsl_pkg::SLOT_W-1:0]     in_slot_value,
  input  logic [wsl_pkg::SLOT_W-1:0]     in_start_slot,
  input  logic [wsl_pkg::SLOT_W-1:0]     in_phase_offset,
  input  logic [wsl_pkg::ATT_W-1:0]      in_attempts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [wsl_pkg::LAT_W-1:0]      out_latency,
  input  logic                           cfg_we,
  input  logic [wsl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wsl_pkg::CFG_DAT_W-1:0]  cfg_wdata
);

  // Address width of the table and width of a count that can reach its depth.
  localparam int AW     = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
  localparam int KW     = $clog2(MAX_ACTIVE + 1);
  localparam int ACC_W  = wsl_pkg::ACC_W;
  localparam int ATT_W  = wsl_pkg::ATT_W;
  localparam int LUT_N  = 2 ** wsl_pkg::IDX_IN_W;

  localparam logic signed [ACC_W-1:0] LAT_MAX_EXT =
    $signed({{(ACC_W - wsl_pkg::LAT_W){1'b0}}, {wsl_pkg::LAT_W{1'b1}}});

  // Configuration registers.
  logic [wsl_pkg::PERIOD_W-1:0] period_r;
  logic [wsl_pkg::ACTIVE_W-1:0] active_r;

  // Sequencer and datapath registers.
  wsl_pkg::wsl_state_t          state_r, state_nxt;
  logic [AW-1:0]                idx_r, idx_nxt;
  logic [KW-1:0]                k_r, k_nxt;
  logic                         single_r, single_nxt;
  logic [wsl_pkg::SLOT_W-1:0]   start_r, start_nxt;
  logic [ATT_W-1:0]             qt_r, qt_nxt;
  logic [KW-1:0]                rem_r, rem_nxt;
  logic [wsl_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SLOT_BITS-1:0]         e0_r, e0_nxt;
  logic [SLOT_BITS-1:0]         cur_r, cur_nxt;
  logic signed [ACC_W-1:0]      acc_r, acc_nxt;
  logic [wsl_pkg::PROD_W-1:0]   prod_r, prod_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [wsl_pkg::LAT_W-1:0]    out_latency_r, out_latency_nxt;

  // Slot table with a registered read port.
  logic [SLOT_BITS-1:0]         slot_mem [MAX_ACTIVE];
  logic [SLOT_BITS-1:0]         rd_data_r;

  // Table position of a load: slot index modulo the table depth.
  logic [AW-1:0]                mod_lut [LUT_N];

  // Combinational helpers.
  logic [SLOT_BITS-1:0]         ent;
  logic signed [ACC_W-1:0]      ent_ext;
  logic signed [ACC_W-1:0]      cur_ext;
  logic signed [ACC_W-1:0]      start_ext;
  logic signed [ACC_W-1:0]      period_ext;
  logic signed [ACC_W-1:0]      c_ext;
  logic [SLOT_BITS-1:0]         c_val;
  logic [AW-1:0]                i_val;
  logic [KW:0]                  trial;
  logic                         hit;
  logic                         last;
  logic                         load_acc;

  for (genvar g = 0; g < LUT_N; g++) begin : g_mod_lut
    assign mod_lut[g] = AW'(g % MAX_ACTIVE);
  end

  // Successor of a table position, wrapping at the active count.
  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] pos,
                                             input logic [KW-1:0] k);
    logic [KW-1:0] inc;
    inc = KW'(pos) + KW'(1);
    if (inc == k) begin
      next_pos = '0;
    end else begin
      next_pos = inc[AW-1:0];
    end
  endfunction

  assign in_ready    = (state_r == wsl_pkg::ST_IDLE);
  assign load_acc    = in_valid && in_ready && (in_action == wsl_pkg::ACT_LOAD);
  assign out_valid   = out_valid_r;
  assign out_latency = out_latency_r;

  // A nonzero phase offset replaces the table by one active slot at zero.
  assign ent        = single_r ? '0 : rd_data_r;
  assign ent_ext    = $signed(ACC_W'(ent));
  assign cur_ext    = $signed(ACC_W'(cur_r));
  assign start_ext  = $signed(ACC_W'(start_r));
  assign period_ext = $signed(ACC_W'(period_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= wsl_pkg::PERIOD_W'(1);
      active_r <= wsl_pkg::ACTIVE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        wsl_pkg::REG_PERIOD: period_r <= cfg_wdata[wsl_pkg::PERIOD_W-1:0];
        wsl_pkg::REG_ACTIVE: active_r <= cfg_wdata[wsl_pkg::ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // The read address follows the next index, so rd_data_r always holds the
  // entry at idx_r and the search and walk read one entry per cycle.
  always_ff @(posedge clk) begin
    if (load_acc) begin
      slot_mem[mod_lut[in_slot_index]] <= SLOT_BITS'(in_slot_value);
    end
    rd_data_r <= slot_mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wsl_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r           <= k_nxt;
    single_r      <= single_nxt;
    start_r       <= start_nxt;
    qt_r          <= qt_nxt;
    rem_r         <= rem_nxt;
    cnt_r         <= cnt_nxt;
    e0_r          <= e0_nxt;
    cur_r         <= cur_nxt;
    acc_r         <= acc_nxt;
    prod_r        <= prod_nxt;
    out_latency_r <= out_latency_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    k_nxt           = k_r;
    single_nxt      = single_r;
    start_nxt       = start_r;
    qt_nxt          = qt_r;
    rem_nxt         = rem_r;
    cnt_nxt         = cnt_r;
    e0_nxt          = e0_r;
    cur_nxt         = cur_r;
    acc_nxt         = acc_r;
    prod_nxt        = prod_r;
    out_valid_nxt   = out_valid_r;
    out_latency_nxt = out_latency_r;
    trial           = {rem_r, qt_r[ATT_W-1]};
    hit             = (ent_ext >= start_ext);
    last            = ((KW'(idx_r) + KW'(1)) == k_r);
    c_val           = hit ? ent : ((idx_r == '0) ? ent : e0_r);
    i_val           = hit ? idx_r : '0;
    c_ext           = $signed(ACC_W'(c_val));

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      wsl_pkg::ST_IDLE: begin
        if (in_valid && (in_action == wsl_pkg::ACT_QUERY)) begin
          single_nxt = (in_phase_offset != '0);
          start_nxt  = in_start_slot;
          if ((in_phase_offset != '0) || (active_r == '0)) begin
            k_nxt = KW'(1);
          end else if (32'(active_r) > MAX_ACTIVE) begin
            k_nxt = KW'(MAX_ACTIVE);
          end else begin
            k_nxt = KW'(active_r);
          end
          // Attempts of zero count as one; the divider works on attempts - 1.
          qt_nxt    = (in_attempts == '0) ? '0 : in_attempts - ATT_W'(1);
          rem_nxt   = '0;
          cnt_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = wsl_pkg::ST_DIV;
        end
      end

      // Restoring division: quotient bits shift in where dividend bits leave.
      wsl_pkg::ST_DIV: begin
        if (trial >= {1'b0, k_r}) begin
          rem_nxt = KW'(trial - {1'b0, k_r});
          qt_nxt  = {qt_r[ATT_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[KW-1:0];
          qt_nxt  = {qt_r[ATT_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + wsl_pkg::DIV_CNT_W'(1);
        if (cnt_r == wsl_pkg::DIV_CNT_W'(ATT_W - 1)) begin
          state_nxt = wsl_pkg::ST_SRCH;
        end
      end

      // First entry at or after the start; entry zero if there is none.
      wsl_pkg::ST_SRCH: begin
        if (idx_r == '0) begin
          e0_nxt = ent;
        end
        if (hit || last) begin
          acc_nxt   = c_ext - start_ext + ((c_ext < start_ext) ? period_ext : '0);
          cur_nxt   = c_val;
          idx_nxt   = next_pos(i_val, k_r);
          state_nxt = wsl_pkg::ST_MUL;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      wsl_pkg::ST_MUL: begin
        prod_nxt  = wsl_pkg::PROD_W'(qt_r) * wsl_pkg::PROD_W'(period_r);
        state_nxt = wsl_pkg::ST_ADDQ;
      end

      wsl_pkg::ST_ADDQ: begin
        acc_nxt   = acc_r + $signed(ACC_W'(prod_r));
        state_nxt = (rem_r == '0) ? wsl_pkg::ST_DONE : wsl_pkg::ST_WALK;
      end

      // One gap per cycle; a wrap back to entry zero adds a whole period.
      wsl_pkg::ST_WALK: begin
        acc_nxt = acc_r + ent_ext - cur_ext + ((idx_r == '0) ? period_ext : '0);
        cur_nxt = ent;
        idx_nxt = next_pos(idx_r, k_r);
        rem_nxt = rem_r - KW'(1);
        if (rem_r == KW'(1)) begin
          state_nxt = wsl_pkg::ST_DONE;
        end
      end

      wsl_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (acc_r[ACC_W-1]) begin
            out_latency_nxt = '0;
          end else if (acc_r > LAT_MAX_EXT) begin
            out_latency_nxt = LAT_MAX_EXT[wsl_pkg::LAT_W-1:0];
          end else begin
            out_latency_nxt = acc_r[wsl_pkg::LAT_W-1:0];
          end
          state_nxt = wsl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = wsl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/wake_slot_latency_core_sva.sv]
// Port-level checker for the wake slot latency core and its bind statement.
// Depends on wsl_pkg and wake_slot_latency_core_macros.svh.
`include "wake_slot_latency_core_macros.svh"

module wsl_sva (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [wsl_pkg::ACTION_W-1:0]  in_action,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [wsl_pkg::LAT_W-1:0]     out_latency
);

  // A stalled result transaction keeps its value.
  `WSL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_latency), "result changed while stalled")

  // A query keeps the block busy for the following cycle.
  `WSL_ASSERT_NEXT(a_query_busy, in_valid && in_ready && (in_action == wsl_pkg::ACT_QUERY), !in_ready, "ready right after a query")

  // A load never stalls the input side.
  `WSL_ASSERT_NEXT(a_load_ready, in_valid && in_ready && (in_action == wsl_pkg::ACT_LOAD), in_ready, "load stalled the input")

  // Leaving reset, the block is ready and holds no result.
  `WSL_ASSERT_NOW(a_reset_state, $past(!rst_n), in_ready && !out_valid, "bad state after reset")

endmodule

bind wake_slot_latency_core wsl_sva u_wsl_sva (.*);
